// ===== rtl/core/pfl_pkg.sv =====
// Package for the page free list allocator: item structs, action and status codes,
// field widths and reset values of the bound registers.
// Depends on nothing.
package pfl_pkg;

    localparam int ADDR_W         = 56;
    localparam int BYTES_W        = 28;
    localparam int MAX_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic [ADDR_W-1:0]  LOWER_RESET = 56'h0000_0080_000000;
    localparam logic [ADDR_W-1:0]  UPPER_RESET = 56'h0000_0086_400000;
    localparam logic [BYTES_W-1:0] BYTES_MAX   = '1;

    // Configuration register indexes.
    typedef enum logic {
        CFG_LOWER = 1'b0,
        CFG_UPPER = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_INIT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        action_t           action;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_address;
        logic [BYTES_W-1:0] free_bytes;
        status_t            status;
    } out_item_t;

endpackage

// ===== rtl/core/page_free_list_allocator.sv =====
// Page free list allocator: a LIFO stack of free page numbers held in one synchronous
// memory, with a fill count, bound registers and a registered result stage.
// Depends on pfl_pkg.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_item   (action, address)
//   m_        out        m_valid / m_ready  m_item   (page_address, free_bytes, status)
//   cfg_      in         cfg_we             cfg_index, cfg_data (lower and upper bound)
//
// Free and count items, and an alloc on an empty stack, go from acceptance through the
// done state back to idle; an alloc that pops a page passes the read state first, as the
// top of the stack comes out of the memory as registered read data.
// Init walks the fill state and then the done state; the single write port of the stack
// memory takes one page number a cycle, and a last fill step finds the end of the range
// or the full stack.
// Reset clears the fill count and the control state and loads the bound registers;
// the stack memory is not cleared, as only entries below the count are ever read.
// A result that waits in the output register does not block acceptance of the next
// item; only its completion waits until the output register is free.
module page_free_list_allocator #(
    parameter int MAX_PAGES  = pfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = pfl_pkg::PAGE_SHIFT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  pfl_pkg::cfg_index_t           cfg_index,
    input  logic [pfl_pkg::ADDR_W-1:0]    cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  pfl_pkg::in_item_t             s_item,

    output logic                          m_valid,
    input  logic                          m_ready,
    output pfl_pkg::out_item_t            m_item
);

    // Width of a stored page number, of a page number with a carry bit (used while
    // filling), of a stack index and of the fill count.
    localparam int PNW = pfl_pkg::ADDR_W - PAGE_SHIFT;
    localparam int PNX = PNW + 1;
    localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW  = $clog2(MAX_PAGES + 1);
    // Width in which the free byte figure is formed before saturation.
    localparam int BW  = (CW + PAGE_SHIFT > pfl_pkg::BYTES_W) ? CW + PAGE_SHIFT
                                                              : pfl_pkg::BYTES_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_FILL = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [pfl_pkg::ADDR_W-1:0]   lower_reg, upper_reg;

    // Result being built for the current item.
    logic [pfl_pkg::ADDR_W-1:0]   res_page_reg, res_page_next;
    logic [pfl_pkg::BYTES_W-1:0]  res_bytes_reg, res_bytes_next;
    pfl_pkg::status_t             res_status_reg, res_status_next;

    // Init walk: next page number to push and the first page number that no longer fits.
    logic [PNX-1:0]               fill_pn_reg, fill_pn_next;
    logic [PNX-1:0]               end_pn_reg, end_pn_next;

    pfl_pkg::out_item_t           out_reg, out_next;
    logic                         m_valid_reg, m_valid_next;

    // Stack memory, one write and one read port, registered read data.
    logic [PNW-1:0]               page_mem [MAX_PAGES];
    logic [PNW-1:0]               rd_data_reg;
    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [PNW-1:0]               mem_wdata;

    logic                         accept;
    logic                         full;
    logic                         free_bad;
    logic [BW-1:0]                bytes_wide;
    logic [pfl_pkg::ADDR_W:0]     lower_round;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign full = (count_reg == CW'(MAX_PAGES));

    // A freed address must be page aligned and lie in [lower, upper).
    assign free_bad = (|s_item.address[PAGE_SHIFT-1:0])
                   || (s_item.address < lower_reg)
                   || (s_item.address >= upper_reg);

    assign bytes_wide  = BW'(count_reg) << PAGE_SHIFT;
    // Lower bound rounded up to a page; the carry bit keeps the sum from wrapping.
    assign lower_round = {1'b0, lower_reg} + (pfl_pkg::ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_page_next   = res_page_reg;
        res_bytes_next  = res_bytes_reg;
        res_status_next = res_status_reg;
        fill_pn_next    = fill_pn_reg;
        end_pn_next     = end_pn_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = s_item.address[pfl_pkg::ADDR_W-1:PAGE_SHIFT];
        mem_raddr       = AW'(count_reg - CW'(1));

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_page_next   = '0;
                    res_bytes_next  = '0;
                    res_status_next = pfl_pkg::STAT_OK;
                    state_next      = ST_DONE;
                    unique case (s_item.action)
                        pfl_pkg::ACT_ALLOC: begin
                            if (count_reg == '0) begin
                                res_status_next = pfl_pkg::STAT_EMPTY;
                            end else begin
                                // Pop: the top entry arrives from the memory next cycle.
                                mem_re     = 1'b1;
                                count_next = count_reg - CW'(1);
                                state_next = ST_READ;
                            end
                        end
                        pfl_pkg::ACT_FREE: begin
                            if (free_bad) begin
                                res_status_next = pfl_pkg::STAT_BAD;
                            end else if (full) begin
                                res_status_next = pfl_pkg::STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pfl_pkg::ACT_COUNT: begin
                            if (bytes_wide > BW'(pfl_pkg::BYTES_MAX)) begin
                                res_bytes_next = pfl_pkg::BYTES_MAX;
                            end else begin
                                res_bytes_next = bytes_wide[pfl_pkg::BYTES_W-1:0];
                            end
                        end
                        pfl_pkg::ACT_INIT: begin
                            fill_pn_next = lower_round[pfl_pkg::ADDR_W:PAGE_SHIFT];
                            end_pn_next  = {1'b0, upper_reg[pfl_pkg::ADDR_W-1:PAGE_SHIFT]};
                            state_next   = ST_FILL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                res_page_next = {rd_data_reg, PAGE_SHIFT'(0)};
                state_next    = ST_DONE;
            end
            ST_FILL: begin
                // One page a cycle until the range is exhausted or the stack is full.
                if (fill_pn_reg >= end_pn_reg) begin
                    state_next = ST_DONE;
                end else if (full) begin
                    res_status_next = pfl_pkg::STAT_FULL;
                    state_next      = ST_DONE;
                end else begin
                    mem_we       = 1'b1;
                    mem_wdata    = fill_pn_reg[PNW-1:0];
                    count_next   = count_reg + CW'(1);
                    fill_pn_next = fill_pn_reg + PNX'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.page_address = res_page_reg;
                    out_next.free_bytes   = res_bytes_reg;
                    out_next.status       = res_status_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Accesses never overlap on one entry: a read is issued only from the idle state,
    // after every write of the previous item has gone into the memory.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= page_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            lower_reg   <= pfl_pkg::LOWER_RESET;
            upper_reg   <= pfl_pkg::UPPER_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    pfl_pkg::CFG_LOWER: lower_reg <= cfg_data;
                    pfl_pkg::CFG_UPPER: upper_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_page_reg   <= res_page_next;
        res_bytes_reg  <= res_bytes_next;
        res_status_reg <= res_status_next;
        fill_pn_reg    <= fill_pn_next;
        end_pn_reg     <= end_pn_next;
        out_reg        <= out_next;
    end

    // The fill count never passes the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PAGES))
        else $error("free page count exceeds stack depth");

    // An alloc on a non-empty stack takes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.action == pfl_pkg::ACT_ALLOC && count_reg != '0)
            |=> count_reg == $past(count_reg) - CW'(1))
        else $error("alloc did not pop exactly one entry");

    // A new result appears only when the result stage hands it over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown outside the hand-over state");

    // The init walk only ever adds entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |=> count_reg >= $past(count_reg))
        else $error("fill count dropped during init");

endmodule
